// ----- sv/tra_pkg.sv -----
// ----------------------------------------------------------------------------
// tra_pkg
// Shared types and constants for the Thumb register-format data-processing ALU.
// ----------------------------------------------------------------------------
package tra_pkg;

	// Operand and shift amount widths.
	localparam int DATA_W  = 32;
	localparam int SHAMT_W = 8;
	localparam int ROT_W   = $clog2(DATA_W);

	// Data-processing opcodes, as carried in the command field.
	typedef enum logic [3:0] {
		OP_AND = 4'd0,
		OP_EOR = 4'd1,
		OP_LSL = 4'd2,
		OP_LSR = 4'd3,
		OP_ASR = 4'd4,
		OP_ADC = 4'd5,
		OP_SBC = 4'd6,
		OP_ROR = 4'd7,
		OP_TST = 4'd8,
		OP_NEG = 4'd9,
		OP_CMP = 4'd10,
		OP_CMN = 4'd11,
		OP_ORR = 4'd12,
		OP_MUL = 4'd13,
		OP_BIC = 4'd14,
		OP_MVN = 4'd15
	} op_t;

	// One result item: write-back value, enable and NZCV flags.
	typedef struct packed {
		logic [DATA_W-1:0] result;
		logic              write_result;
		logic              negative_flag;
		logic              zero_flag;
		logic              carry_flag;
		logic              overflow_flag;
	} alu_out_t;

	// Shifter result with its carry-out.
	typedef struct packed {
		logic [DATA_W-1:0] value;
		logic              carry;
	} shift_out_t;

endpackage

// ----- sv/thumb_register_alu_top.sv -----
// ----------------------------------------------------------------------------
// thumb_register_alu_top
// Thumb register-format data-processing ALU with registered input and output.
// ----------------------------------------------------------------------------
// Usage:
// One item on the input channel carries command, operand_n, operand_m,
// carry_in and overflow_in; it is taken when in_valid and in_ready are both
// high. One result item leaves on the output channel for every input item,
// carrying result, write_result and the NZCV flags, taken when out_valid
// and out_ready are both high.
// Path: an accepted item lands in the input register and is presented
// on the output from the result register. Throughput: one item per cycle
// while out_ready is high; the whole operation, including the 32x32
// low-word multiply, is evaluated between the two registers.
// Reset: arst_n clears both valid bits at once; no item is held afterward.
// Stall: when out_ready is low the result stays put; the input register
// still takes one more item, and in_ready drops only when both are full.
// ----------------------------------------------------------------------------
module thumb_register_alu_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [3:0]                  command,
	input  logic [tra_pkg::DATA_W-1:0]  operand_n,
	input  logic [tra_pkg::DATA_W-1:0]  operand_m,
	input  logic                        carry_in,
	input  logic                        overflow_in,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [tra_pkg::DATA_W-1:0]  result,
	output logic                        write_result,
	output logic                        negative_flag,
	output logic                        zero_flag,
	output logic                        carry_flag,
	output logic                        overflow_flag
);

	logic                       vld_s1;
	tra_pkg::op_t               op_s1;
	logic [tra_pkg::DATA_W-1:0] n_s1;
	logic [tra_pkg::DATA_W-1:0] m_s1;
	logic                       c_s1;
	logic                       v_s1;
	logic                       vld_s2;
	tra_pkg::alu_out_t          res_s2;
	tra_pkg::alu_out_t          alu_out;
	logic                       adv_s2;

	// Stage moves forward when the next one is empty or draining.
	assign adv_s2   = !vld_s2 || out_ready;
	assign in_ready = !vld_s1 || adv_s2;

	// Input register valid bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	// Input register payload.
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			op_s1 <= tra_pkg::op_t'(command);
			n_s1  <= operand_n;
			m_s1  <= operand_m;
			c_s1  <= carry_in;
			v_s1  <= overflow_in;
		end
	end

	tra_alu u_alu (
		.op          (op_s1),
		.operand_n   (n_s1),
		.operand_m   (m_s1),
		.carry_in    (c_s1),
		.overflow_in (v_s1),
		.alu_out     (alu_out)
	);

	// Result register valid bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv_s2) begin
			vld_s2 <= vld_s1;
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (adv_s2 && vld_s1) begin
			res_s2 <= alu_out;
		end
	end

	assign out_valid     = vld_s2;
	assign result        = res_s2.result;
	assign write_result  = res_s2.write_result;
	assign negative_flag = res_s2.negative_flag;
	assign zero_flag     = res_s2.zero_flag;
	assign carry_flag    = res_s2.carry_flag;
	assign overflow_flag = res_s2.overflow_flag;

endmodule

// ----- sv/tra_shifter.sv -----
// ----------------------------------------------------------------------------
// tra_shifter
// Register-controlled barrel shifter for LSL, LSR, ASR and ROR with carry-out.
// ----------------------------------------------------------------------------
module tra_shifter (
	input  tra_pkg::op_t                  op,
	input  logic [tra_pkg::DATA_W-1:0]    value,
	input  logic [tra_pkg::SHAMT_W-1:0]   amount,
	input  logic                          carry_in,
	output tra_pkg::shift_out_t           shift_out
);

	localparam int W = tra_pkg::DATA_W;

	logic [tra_pkg::ROT_W-1:0] amt_lo;
	logic                      amt_zero;
	logic                      amt_lt_w;
	logic                      amt_eq_w;
	logic [W:0]                lsl_wide;
	logic [W:0]                lsr_wide;
	logic signed [W:0]         asr_wide;
	logic [2*W-1:0]            ror_wide;

	assign amt_lo   = amount[tra_pkg::ROT_W-1:0];
	assign amt_zero = (amount == '0);
	assign amt_lt_w = (amount < tra_pkg::SHAMT_W'(W));
	assign amt_eq_w = (amount == tra_pkg::SHAMT_W'(W));

	// Extra bit beyond the value catches the last bit shifted out.
	assign lsl_wide = {1'b0, value} << amt_lo;
	assign lsr_wide = {value, 1'b0} >> amt_lo;
	assign asr_wide = $signed({value, 1'b0}) >>> amt_lo;
	assign ror_wide = {value, value} >> amt_lo;

	// Select the result and carry, covering the zero, full-width and larger amounts.
	always_comb begin
		shift_out.value = value;
		shift_out.carry = carry_in;
		case (op)
			tra_pkg::OP_LSL: begin
				if (amt_zero) begin
					shift_out.value = value;
				end else if (amt_lt_w) begin
					shift_out.value = lsl_wide[W-1:0];
					shift_out.carry = lsl_wide[W];
				end else begin
					shift_out.value = '0;
					shift_out.carry = amt_eq_w & value[0];
				end
			end
			tra_pkg::OP_LSR: begin
				if (amt_zero) begin
					shift_out.value = value;
				end else if (amt_lt_w) begin
					shift_out.value = lsr_wide[W:1];
					shift_out.carry = lsr_wide[0];
				end else begin
					shift_out.value = '0;
					shift_out.carry = amt_eq_w & value[W-1];
				end
			end
			tra_pkg::OP_ASR: begin
				if (amt_zero) begin
					shift_out.value = value;
				end else if (amt_lt_w) begin
					shift_out.value = asr_wide[W:1];
					shift_out.carry = asr_wide[0];
				end else begin
					shift_out.value = {W{value[W-1]}};
					shift_out.carry = value[W-1];
				end
			end
			tra_pkg::OP_ROR: begin
				if (!amt_zero) begin
					shift_out.value = ror_wide[W-1:0];
					shift_out.carry = ror_wide[W-1];
				end
			end
			default: begin
				shift_out.value = value;
				shift_out.carry = carry_in;
			end
		endcase
	end

endmodule

// ----- sv/tra_alu.sv -----
// ----------------------------------------------------------------------------
// tra_alu
// Combinational datapath: adder, logic unit, multiplier, shifter and flags.
// ----------------------------------------------------------------------------
module tra_alu (
	input  tra_pkg::op_t                  op,
	input  logic [tra_pkg::DATA_W-1:0]    operand_n,
	input  logic [tra_pkg::DATA_W-1:0]    operand_m,
	input  logic                          carry_in,
	input  logic                          overflow_in,
	output tra_pkg::alu_out_t             alu_out
);

	localparam int W = tra_pkg::DATA_W;

	logic [W-1:0]        add_a;
	logic [W-1:0]        add_b;
	logic                add_ci;
	logic [W:0]          add_sum;
	logic                add_v;
	logic [W-1:0]        product;
	logic [W-1:0]        res;
	logic                carry;
	logic                overflow;
	tra_pkg::shift_out_t shift_out;

	// Shared adder operand selection for the arithmetic and compare operations.
	always_comb begin
		add_a  = operand_n;
		add_b  = operand_m;
		add_ci = carry_in;
		case (op)
			tra_pkg::OP_ADC: begin
				add_b  = operand_m;
				add_ci = carry_in;
			end
			tra_pkg::OP_SBC: begin
				add_b  = ~operand_m;
				add_ci = carry_in;
			end
			tra_pkg::OP_NEG: begin
				add_a  = ~operand_m;
				add_b  = '0;
				add_ci = 1'b1;
			end
			tra_pkg::OP_CMP: begin
				add_b  = ~operand_m;
				add_ci = 1'b1;
			end
			tra_pkg::OP_CMN: begin
				add_b  = operand_m;
				add_ci = 1'b0;
			end
			default: begin
				add_a  = operand_n;
				add_b  = operand_m;
				add_ci = carry_in;
			end
		endcase
	end

	assign add_sum = {1'b0, add_a} + {1'b0, add_b} + {{W{1'b0}}, add_ci};
	assign add_v   = ~(add_a[W-1] ^ add_b[W-1]) & (add_a[W-1] ^ add_sum[W-1]);

	// Low word of the product only.
	assign product = operand_n * operand_m;

	tra_shifter u_shifter (
		.op        (op),
		.value     (operand_n),
		.amount    (operand_m[tra_pkg::SHAMT_W-1:0]),
		.carry_in  (carry_in),
		.shift_out (shift_out)
	);

	// Result and carry/overflow selection; untouched flags pass through.
	always_comb begin
		res      = '0;
		carry    = carry_in;
		overflow = overflow_in;
		case (op)
			tra_pkg::OP_AND, tra_pkg::OP_TST: res = operand_n & operand_m;
			tra_pkg::OP_EOR: res = operand_n ^ operand_m;
			tra_pkg::OP_ORR: res = operand_n | operand_m;
			tra_pkg::OP_BIC: res = operand_n & ~operand_m;
			tra_pkg::OP_MVN: res = ~operand_m;
			tra_pkg::OP_MUL: res = product;
			tra_pkg::OP_LSL, tra_pkg::OP_LSR, tra_pkg::OP_ASR, tra_pkg::OP_ROR: begin
				res   = shift_out.value;
				carry = shift_out.carry;
			end
			tra_pkg::OP_ADC, tra_pkg::OP_SBC, tra_pkg::OP_NEG,
			tra_pkg::OP_CMP, tra_pkg::OP_CMN: begin
				res      = add_sum[W-1:0];
				carry    = add_sum[W];
				overflow = add_v;
			end
			default: res = '0;
		endcase
	end

	// TST and the compares set flags only; N and Z follow the computed value.
	assign alu_out.result        = res;
	assign alu_out.write_result  = !(op == tra_pkg::OP_TST || op == tra_pkg::OP_CMP ||
		op == tra_pkg::OP_CMN);
	assign alu_out.negative_flag = res[W-1];
	assign alu_out.zero_flag     = (res == '0);
	assign alu_out.carry_flag    = carry;
	assign alu_out.overflow_flag = overflow;

endmodule

// ----- sv/tra_checker.sv -----
// ----------------------------------------------------------------------------
// tra_checker
// Port-level checks for the Thumb register ALU, bound to the top level.
// ----------------------------------------------------------------------------
module tra_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic                        in_ready,
	input  logic                        out_valid,
	input  logic                        out_ready,
	input  logic [tra_pkg::DATA_W-1:0]  result,
	input  logic                        negative_flag,
	input  logic                        zero_flag
);

	// A stalled result item holds its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(result))
		else $error("result item changed while stalled");

	// N always mirrors the sign bit of the presented result.
	a_neg_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> negative_flag == result[tra_pkg::DATA_W-1])
		else $error("negative flag does not match result sign");

	// Z is set exactly when the presented result is zero.
	a_zero_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> zero_flag == (result == '0))
		else $error("zero flag does not match result");

	// An accepted item reaches the output when the receiver keeps draining.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready ##1 out_ready |=> out_valid)
		else $error("accepted item did not reach the output");

endmodule

bind thumb_register_alu_top tra_checker u_tra_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_ready      (in_ready),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.result        (result),
	.negative_flag (negative_flag),
	.zero_flag     (zero_flag)
);

// ----- tb/sv/alu_result_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alu_result_checker
// Watches both channels of the Thumb register-format ALU, computes the expected
// result item for every accepted input item and compares it with the item that
// leaves the block, field by field and in order.
// ----------------------------------------------------------------------------
module alu_result_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic                       in_ready,
	input  logic [3:0]                 command,
	input  logic [tra_pkg::DATA_W-1:0] operand_n,
	input  logic [tra_pkg::DATA_W-1:0] operand_m,
	input  logic                       carry_in,
	input  logic                       overflow_in,
	input  logic                       out_valid,
	input  logic                       out_ready,
	input  logic [tra_pkg::DATA_W-1:0] result,
	input  logic                       write_result,
	input  logic                       negative_flag,
	input  logic                       zero_flag,
	input  logic                       carry_flag,
	input  logic                       overflow_flag,
	output int                         fail_count,
	output int                         in_flight
);

	// Predicted result items, oldest first.
	tra_pkg::alu_out_t awaited_results[$];
	int                mismatches = 0;

	// Adder shared by the arithmetic operations: {V, C, sum}.
	function automatic logic [tra_pkg::DATA_W+1:0] add_with_carry(
			logic [tra_pkg::DATA_W-1:0] x, logic [tra_pkg::DATA_W-1:0] y, logic c0);
		logic [tra_pkg::DATA_W:0] sum;
		logic                     ovf;
		sum = {1'b0, x} + {1'b0, y} + {{tra_pkg::DATA_W{1'b0}}, c0};
		ovf = ~(x[tra_pkg::DATA_W-1] ^ y[tra_pkg::DATA_W-1]) &
			(x[tra_pkg::DATA_W-1] ^ sum[tra_pkg::DATA_W-1]);
		return {ovf, sum};
	endfunction

	// Expected result item for one instruction.
	function automatic tra_pkg::alu_out_t alu_compute(tra_pkg::op_t op,
			logic [tra_pkg::DATA_W-1:0] a, logic [tra_pkg::DATA_W-1:0] b,
			logic cin, logic vin);
		tra_pkg::alu_out_t          o;
		logic [tra_pkg::DATA_W-1:0] r;
		logic                       c;
		logic                       v;
		logic                       wr;
		int unsigned                sh;
		int unsigned                k;
		sh = 32'(b[tra_pkg::SHAMT_W-1:0]);
		r  = '0;
		c  = cin;
		v  = vin;
		wr = 1'b1;
		case (op)
			tra_pkg::OP_AND: r = a & b;
			tra_pkg::OP_EOR: r = a ^ b;
			tra_pkg::OP_LSL: begin
				if (sh == 0) begin
					r = a;
				end else if (sh < 32) begin
					r = a << sh;
					c = a[32-sh];
				end else if (sh == 32) begin
					c = a[0];
				end else begin
					c = 1'b0;
				end
			end
			tra_pkg::OP_LSR: begin
				if (sh == 0) begin
					r = a;
				end else if (sh < 32) begin
					r = a >> sh;
					c = a[sh-1];
				end else if (sh == 32) begin
					c = a[31];
				end else begin
					c = 1'b0;
				end
			end
			tra_pkg::OP_ASR: begin
				if (sh == 0) begin
					r = a;
				end else if (sh < 32) begin
					r = 32'($signed(a) >>> sh);
					c = a[sh-1];
				end else begin
					r = {tra_pkg::DATA_W{a[31]}};
					c = a[31];
				end
			end
			tra_pkg::OP_ADC: {v, c, r} = add_with_carry(a, b, cin);
			tra_pkg::OP_SBC: {v, c, r} = add_with_carry(a, ~b, cin);
			tra_pkg::OP_ROR: begin
				if (sh == 0) begin
					r = a;
				end else begin
					k = sh % 32;
					r = (k == 0) ? a : ((a >> k) | (a << (32 - k)));
					c = r[31];
				end
			end
			tra_pkg::OP_TST: begin
				r  = a & b;
				wr = 1'b0;
			end
			tra_pkg::OP_NEG: {v, c, r} = add_with_carry(~b, '0, 1'b1);
			tra_pkg::OP_CMP: begin
				{v, c, r} = add_with_carry(a, ~b, 1'b1);
				wr = 1'b0;
			end
			tra_pkg::OP_CMN: begin
				{v, c, r} = add_with_carry(a, b, 1'b0);
				wr = 1'b0;
			end
			tra_pkg::OP_ORR: r = a | b;
			tra_pkg::OP_MUL: r = a * b;
			tra_pkg::OP_BIC: r = a & ~b;
			default: r = ~b;
		endcase
		o.result        = r;
		o.write_result  = wr;
		o.negative_flag = r[31];
		o.zero_flag     = (r == '0);
		o.carry_flag    = c;
		o.overflow_flag = v;
		return o;
	endfunction

	// Compare one field; X or Z on the output counts as a mismatch.
	task automatic check_field(string name, logic [tra_pkg::DATA_W-1:0] want,
			logic [tra_pkg::DATA_W-1:0] got);
		if (want !== got) begin
			$error("%s mismatch: expected %h, actual %h", name, want, got);
			mismatches++;
		end
	endtask

	// Record accepted input items and check accepted result items.
	always @(posedge clk) begin
		tra_pkg::alu_out_t want;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				awaited_results.push_back(alu_compute(tra_pkg::op_t'(command),
					operand_n, operand_m, carry_in, overflow_in));
			end
			if (out_valid && out_ready) begin
				if (awaited_results.size() == 0) begin
					$error("result item with no prediction pending: result %h", result);
					mismatches++;
				end else begin
					want = awaited_results.pop_front();
					check_field("result", want.result, result);
					check_field("write_result", 32'(want.write_result), 32'(write_result));
					check_field("negative_flag", 32'(want.negative_flag), 32'(negative_flag));
					check_field("zero_flag", 32'(want.zero_flag), 32'(zero_flag));
					check_field("carry_flag", 32'(want.carry_flag), 32'(carry_flag));
					check_field("overflow_flag", 32'(want.overflow_flag), 32'(overflow_flag));
				end
			end
		end
		fail_count <= mismatches;
		in_flight  <= awaited_results.size();
	end

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the Thumb register-format ALU: a directed set of
// edge cases for every opcode, then random instructions with biased operands
// and shift amounts, under random idling on both channels, a long output
// stall and a full drain partway through.
// ----------------------------------------------------------------------------
module tb;

	localparam int RANDOM_ITEMS = 550;
	localparam int HOLD_CYCLES  = 120;
	localparam int IDLE_LIMIT   = 2000;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       in_valid = 1'b0;
	logic                       in_ready;
	logic [3:0]                 command = '0;
	logic [tra_pkg::DATA_W-1:0] operand_n = '0;
	logic [tra_pkg::DATA_W-1:0] operand_m = '0;
	logic                       carry_in = 1'b0;
	logic                       overflow_in = 1'b0;
	logic                       out_valid;
	logic                       out_ready = 1'b0;
	logic [tra_pkg::DATA_W-1:0] result;
	logic                       write_result;
	logic                       negative_flag;
	logic                       zero_flag;
	logic                       carry_flag;
	logic                       overflow_flag;

	int fail_count;
	int in_flight;
	int idle_cycles = 0;
	logic calm = 1'b0;
	logic hold_req = 1'b0;

	thumb_register_alu_top u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.command(command), .operand_n(operand_n), .operand_m(operand_m),
		.carry_in(carry_in), .overflow_in(overflow_in),
		.out_valid(out_valid), .out_ready(out_ready),
		.result(result), .write_result(write_result),
		.negative_flag(negative_flag), .zero_flag(zero_flag),
		.carry_flag(carry_flag), .overflow_flag(overflow_flag)
	);

	alu_result_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.command(command), .operand_n(operand_n), .operand_m(operand_m),
		.carry_in(carry_in), .overflow_in(overflow_in),
		.out_valid(out_valid), .out_ready(out_ready),
		.result(result), .write_result(write_result),
		.negative_flag(negative_flag), .zero_flag(zero_flag),
		.carry_flag(carry_flag), .overflow_flag(overflow_flag),
		.fail_count(fail_count), .in_flight(in_flight)
	);

	// 2 ns clock.
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Result side: random back-pressure, one long hold-off on request.
	always @(posedge clk) begin
		static int  hold_left = 0;
		static bit  hold_done = 1'b0;
		if (hold_req && !hold_done) begin
			hold_left = HOLD_CYCLES;
			hold_done = 1'b1;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else if (calm) begin
			out_ready <= 1'b1;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= 33);
		end
	end

	// Watchdog on cycles with no item accepted on either channel.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= IDLE_LIMIT) begin
				$display("FAILURE");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	// Offer one instruction, after an optional random gap, and wait until taken.
	task automatic send_instr(tra_pkg::op_t op, logic [tra_pkg::DATA_W-1:0] n,
			logic [tra_pkg::DATA_W-1:0] m, logic c, logic v);
		if (!calm && $urandom_range(0, 99) < 33) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 2)) @(posedge clk);
		end
		in_valid    <= 1'b1;
		command     <= op;
		operand_n   <= n;
		operand_m   <= m;
		carry_in    <= c;
		overflow_in <= v;
		do @(posedge clk); while (!in_ready);
	endtask

	// Stop offering and wait until every predicted result has come out.
	task automatic drain_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (in_flight != 0);
	endtask

	// Operand values biased toward the boundaries of the 32-bit range.
	function automatic logic [tra_pkg::DATA_W-1:0] pick_operand();
		case ($urandom_range(0, 7))
			0: return 32'h0000_0000;
			1: return 32'hffff_ffff;
			2: return 32'h8000_0000;
			3: return 32'h7fff_ffff;
			4: return 32'h0000_0001;
			default: return $urandom;
		endcase
	endfunction

	// Shift amounts covering zero, in-range, exactly 32, multiples and beyond.
	function automatic logic [tra_pkg::SHAMT_W-1:0] pick_shift();
		case ($urandom_range(0, 5))
			0: return 8'd0;
			1, 5: return 8'($urandom_range(1, 31));
			2: return 8'd32;
			3: return {3'($urandom_range(1, 7)), 5'b0};
			default: return 8'($urandom_range(33, 255));
		endcase
	endfunction

	initial begin
		tra_pkg::op_t               op;
		logic [tra_pkg::DATA_W-1:0] n;
		logic [tra_pkg::DATA_W-1:0] m;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed edge cases for every opcode.
		send_instr(tra_pkg::OP_AND, 32'hffff_ffff, 32'h8000_0001, 1'b1, 1'b1);
		send_instr(tra_pkg::OP_EOR, 32'hffff_ffff, 32'hffff_ffff, 1'b0, 1'b0);
		send_instr(tra_pkg::OP_LSL, 32'h8000_0001, 32'h0000_0000, 1'b1, 1'b0);
		send_instr(tra_pkg::OP_LSL, 32'h8000_0001, 32'h0000_0001, 1'b0, 1'b1);
		send_instr(tra_pkg::OP_LSL, 32'h0000_0003, 32'hffff_ff1f, 1'b0, 1'b0);
		send_instr(tra_pkg::OP_LSL, 32'h0000_0001, 32'h0000_0020, 1'b0, 1'b0);
		send_instr(tra_pkg::OP_LSL, 32'hffff_ffff, 32'h0000_0021, 1'b1, 1'b0);
		send_instr(tra_pkg::OP_LSR, 32'h8000_0000, 32'h0000_0020, 1'b0, 1'b0);
		send_instr(tra_pkg::OP_LSR, 32'hffff_ffff, 32'h0000_00ff, 1'b1, 1'b1);
		send_instr(tra_pkg::OP_LSR, 32'h0000_0001, 32'h0000_0001, 1'b0, 1'b0);
		send_instr(tra_pkg::OP_ASR, 32'h8000_0000, 32'h0000_0028, 1'b0, 1'b0);
		send_instr(tra_pkg::OP_ASR, 32'h7fff_ffff, 32'h0000_0020, 1'b1, 1'b0);
		send_instr(tra_pkg::OP_ASR, 32'h8000_0000, 32'h0000_001f, 1'b0, 1'b1);
		send_instr(tra_pkg::OP_ADC, 32'h7fff_ffff, 32'h0000_0000, 1'b1, 1'b0);
		send_instr(tra_pkg::OP_ADC, 32'hffff_ffff, 32'hffff_ffff, 1'b1, 1'b0);
		send_instr(tra_pkg::OP_SBC, 32'h8000_0000, 32'h0000_0001, 1'b1, 1'b0);
		send_instr(tra_pkg::OP_SBC, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b1);
		send_instr(tra_pkg::OP_ROR, 32'h8000_0001, 32'h0000_0040, 1'b0, 1'b0);
		send_instr(tra_pkg::OP_ROR, 32'h0000_00ff, 32'h0000_0008, 1'b0, 1'b0);
		send_instr(tra_pkg::OP_ROR, 32'h1234_5678, 32'h0000_0000, 1'b1, 1'b1);
		send_instr(tra_pkg::OP_TST, 32'h0f0f_0f0f, 32'hf0f0_f0f0, 1'b1, 1'b0);
		send_instr(tra_pkg::OP_NEG, 32'hdead_beef, 32'h8000_0000, 1'b0, 1'b0);
		send_instr(tra_pkg::OP_NEG, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b1);
		send_instr(tra_pkg::OP_CMP, 32'h1234_5678, 32'h1234_5678, 1'b0, 1'b0);
		send_instr(tra_pkg::OP_CMN, 32'h7fff_ffff, 32'h0000_0001, 1'b1, 1'b0);
		send_instr(tra_pkg::OP_ORR, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0);
		send_instr(tra_pkg::OP_MUL, 32'hffff_ffff, 32'hffff_ffff, 1'b1, 1'b1);
		send_instr(tra_pkg::OP_BIC, 32'hffff_ffff, 32'h0000_ffff, 1'b0, 1'b0);
		send_instr(tra_pkg::OP_MVN, 32'h0000_0000, 32'hffff_ffff, 1'b1, 1'b0);

		// Random instructions; a calm stretch, one long output hold-off and
		// one full drain fall inside this part.
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			calm <= (i >= 250 && i < 330);
			if (i == 120) begin
				hold_req <= 1'b1;
			end
			if (i == 420) begin
				drain_results();
			end
			op = tra_pkg::op_t'($urandom_range(0, 15));
			n  = pick_operand();
			m  = pick_operand();
			if (op inside {tra_pkg::OP_LSL, tra_pkg::OP_LSR, tra_pkg::OP_ASR,
					tra_pkg::OP_ROR}) begin
				m[tra_pkg::SHAMT_W-1:0] = pick_shift();
			end
			send_instr(op, n, m, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
		end

		drain_results();
		repeat (10) @(posedge clk);
		if (fail_count == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
sv/tra_pkg.sv
sv/tra_shifter.sv
sv/tra_alu.sv
sv/thumb_register_alu_top.sv
sv/tra_checker.sv
tb/sv/alu_result_checker.sv
tb/sv/tb.sv
